>>> hdl/y2b_pkg.sv
// ----------------------------------------------------------------------------
// y2b_pkg
// Types and constants shared by the YUYV to BGR converter modules.
// ----------------------------------------------------------------------------
package y2b_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned LUMA_W   = 8;
  localparam int unsigned CHROMA_W = 8;
  localparam int unsigned LPROD_W  = COEF_W + LUMA_W + 1;
  localparam int unsigned CPROD_W  = COEF_W + CHROMA_W;
  localparam int unsigned SUM_W    = LPROD_W + 2;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam logic [PIX_W-1:0] LUMA_LO   = 8'd16;
  localparam logic [PIX_W-1:0] LUMA_HI   = 8'd235;
  localparam logic [PIX_W-1:0] CHROMA_LO = 8'd16;
  localparam logic [PIX_W-1:0] CHROMA_HI = 8'd240;
  localparam logic [LUMA_W-1:0] LUMA_SPAN = 8'd219;
  localparam logic signed [CHROMA_W-1:0] CHROMA_MIN = -8'sd112;
  localparam logic signed [CHROMA_W-1:0] CHROMA_MAX = 8'sd112;

  localparam logic signed [COEF_W-1:0] LUMA_GAIN_RST     = 16'sd4769;
  localparam logic signed [COEF_W-1:0] RED_FROM_CR_RST   = 16'sd6512;
  localparam logic signed [COEF_W-1:0] GREEN_FROM_CB_RST = -16'sd1598;
  localparam logic signed [COEF_W-1:0] GREEN_FROM_CR_RST = -16'sd3316;
  localparam logic signed [COEF_W-1:0] BLUE_FROM_CB_RST  = 16'sd8230;

  typedef enum logic [2:0] {
    REG_LUMA_GAIN     = 3'd0,
    REG_RED_FROM_CR   = 3'd1,
    REG_GREEN_FROM_CB = 3'd2,
    REG_GREEN_FROM_CR = 3'd3,
    REG_BLUE_FROM_CB  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
    logic             last_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] blue_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] red_second;
    logic             last_out;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] luma_gain;
    logic signed [COEF_W-1:0] red_from_cr;
    logic signed [COEF_W-1:0] green_from_cb;
    logic signed [COEF_W-1:0] green_from_cr;
    logic signed [COEF_W-1:0] blue_from_cb;
  } coef_t;

  typedef struct packed {
    logic [LUMA_W-1:0]          luma_first;
    logic [LUMA_W-1:0]          luma_second;
    logic signed [CHROMA_W-1:0] cb;
    logic signed [CHROMA_W-1:0] cr;
  } comp_t;

  typedef struct packed {
    logic signed [CPROD_W-1:0] blue_cb;
    logic signed [CPROD_W-1:0] green_cb;
    logic signed [CPROD_W-1:0] green_cr;
    logic signed [CPROD_W-1:0] red_cr;
  } chroma_terms_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } bgr_t;

endpackage

>>> hdl/y2b_prep.sv
// ----------------------------------------------------------------------------
// y2b_prep
// Clamps luma and chroma to their legal ranges and removes the offsets.
// ----------------------------------------------------------------------------
module y2b_prep (
  input  logic              clk,
  input  y2b_pkg::in_item_t item_i,
  output y2b_pkg::comp_t    comp_o
);

  y2b_pkg::comp_t comp_r;
  y2b_pkg::comp_t comp_nxt;

  function automatic logic [y2b_pkg::LUMA_W-1:0] clamp_luma(
    input logic [y2b_pkg::PIX_W-1:0] v
  );
    logic [y2b_pkg::PIX_W-1:0] d;
    d = v - y2b_pkg::LUMA_LO;
    if (v < y2b_pkg::LUMA_LO) begin
      return '0;
    end else if (v > y2b_pkg::LUMA_HI) begin
      return y2b_pkg::LUMA_SPAN;
    end
    return d;
  endfunction

  function automatic logic signed [y2b_pkg::CHROMA_W-1:0] clamp_chroma(
    input logic [y2b_pkg::PIX_W-1:0] v
  );
    if (v < y2b_pkg::CHROMA_LO) begin
      return y2b_pkg::CHROMA_MIN;
    end else if (v > y2b_pkg::CHROMA_HI) begin
      return y2b_pkg::CHROMA_MAX;
    end
    return $signed({~v[y2b_pkg::PIX_W-1], v[y2b_pkg::PIX_W-2:0]});
  endfunction

  always_comb begin
    comp_nxt.luma_first  = clamp_luma(item_i.luma_first);
    comp_nxt.luma_second = clamp_luma(item_i.luma_second);
    comp_nxt.cb          = clamp_chroma(item_i.chroma_blue);
    comp_nxt.cr          = clamp_chroma(item_i.chroma_red);
  end

  always_ff @(posedge clk) begin
    comp_r <= comp_nxt;
  end

  assign comp_o = comp_r;

endmodule

>>> hdl/y2b_chroma.sv
// ----------------------------------------------------------------------------
// y2b_chroma
// Shared chroma products, computed once per item for both pixel lanes.
// ----------------------------------------------------------------------------
module y2b_chroma (
  input  logic                   clk,
  input  y2b_pkg::coef_t         coef_i,
  input  y2b_pkg::comp_t         comp_i,
  output y2b_pkg::chroma_terms_t terms_o
);

  y2b_pkg::chroma_terms_t terms_r;
  y2b_pkg::chroma_terms_t terms_nxt;

  always_comb begin
    terms_nxt.blue_cb  = coef_i.blue_from_cb * comp_i.cb;
    terms_nxt.green_cb = coef_i.green_from_cb * comp_i.cb;
    terms_nxt.green_cr = coef_i.green_from_cr * comp_i.cr;
    terms_nxt.red_cr   = coef_i.red_from_cr * comp_i.cr;
  end

  always_ff @(posedge clk) begin
    terms_r <= terms_nxt;
  end

  assign terms_o = terms_r;

endmodule

>>> hdl/y2b_lane.sv
// ----------------------------------------------------------------------------
// y2b_lane
// One pixel lane: luma product, color sums, floor shift and saturation.
// ----------------------------------------------------------------------------
module y2b_lane #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                           clk,
  input  logic signed [y2b_pkg::COEF_W-1:0] luma_gain_i,
  input  logic [y2b_pkg::LUMA_W-1:0]     luma_i,
  input  y2b_pkg::chroma_terms_t         terms_i,
  output y2b_pkg::bgr_t                  pixel_o
);

  logic signed [y2b_pkg::LPROD_W-1:0] luma_prod_r;
  logic signed [y2b_pkg::LPROD_W-1:0] luma_prod_nxt;
  logic signed [y2b_pkg::SUM_W-1:0]   blue_sum;
  logic signed [y2b_pkg::SUM_W-1:0]   green_sum;
  logic signed [y2b_pkg::SUM_W-1:0]   red_sum;

  function automatic logic [y2b_pkg::PIX_W-1:0] sat_byte(
    input logic signed [y2b_pkg::SUM_W-1:0] s
  );
    if (s[y2b_pkg::SUM_W-1]) begin
      return '0;
    end else if (|s[y2b_pkg::SUM_W-2:FRAC_BITS+y2b_pkg::PIX_W]) begin
      return '1;
    end
    return s[FRAC_BITS+y2b_pkg::PIX_W-1:FRAC_BITS];
  endfunction

  assign luma_prod_nxt = luma_gain_i * $signed({1'b0, luma_i});

  always_ff @(posedge clk) begin
    luma_prod_r <= luma_prod_nxt;
  end

  always_comb begin
    blue_sum  = y2b_pkg::SUM_W'(luma_prod_r) + y2b_pkg::SUM_W'(terms_i.blue_cb);
    green_sum = y2b_pkg::SUM_W'(luma_prod_r) + y2b_pkg::SUM_W'(terms_i.green_cb)
              + y2b_pkg::SUM_W'(terms_i.green_cr);
    red_sum   = y2b_pkg::SUM_W'(luma_prod_r) + y2b_pkg::SUM_W'(terms_i.red_cr);
    pixel_o.blue  = sat_byte(blue_sum);
    pixel_o.green = sat_byte(green_sum);
    pixel_o.red   = sat_byte(red_sum);
  end

endmodule

>>> hdl/yuyv_to_bgr_converter.sv
// ----------------------------------------------------------------------------
// yuyv_to_bgr_converter
// YUYV 4:2:2 macropixel to two BGR888 pixels, BT.601, programmable weights.
// Pipeline registers: clamp, chroma and luma products, output; out_valid tracks them.
// Throughput: one item per cycle; busy stays low, two pixel lanes run in
// parallel behind a shared chroma multiplier stage and a merging register.
// Reset: rst_n clears the pipeline valids and loads the default Q12 weights.
// ----------------------------------------------------------------------------
module yuyv_to_bgr_converter #(
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  y2b_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output y2b_pkg::out_item_t            out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [y2b_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [y2b_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [y2b_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  y2b_pkg::coef_t         coef_r;
  y2b_pkg::coef_t         coef_nxt;
  y2b_pkg::comp_t         comp;
  y2b_pkg::chroma_terms_t terms;
  y2b_pkg::bgr_t          pixel_first;
  y2b_pkg::bgr_t          pixel_second;
  y2b_pkg::out_item_t     out_r;
  y2b_pkg::out_item_t     out_nxt;
  y2b_pkg::reg_idx_t      cfg_idx;
  logic                   cfg_wr;
  logic                   accept;
  logic                   vld_a_r;
  logic                   vld_b_r;
  logic                   out_valid_r;
  logic                   last_a_r;
  logic                   last_b_r;
  logic signed [y2b_pkg::COEF_W-1:0] rd_coef;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign cfg_pready = 1'b1;
  assign cfg_idx    = y2b_pkg::reg_idx_t'(cfg_paddr[y2b_pkg::ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    coef_nxt = coef_r;
    rd_coef  = '0;
    case (cfg_idx)
      y2b_pkg::REG_LUMA_GAIN: begin
        rd_coef = coef_r.luma_gain;
        if (cfg_wr) coef_nxt.luma_gain = cfg_pwdata[y2b_pkg::COEF_W-1:0];
      end
      y2b_pkg::REG_RED_FROM_CR: begin
        rd_coef = coef_r.red_from_cr;
        if (cfg_wr) coef_nxt.red_from_cr = cfg_pwdata[y2b_pkg::COEF_W-1:0];
      end
      y2b_pkg::REG_GREEN_FROM_CB: begin
        rd_coef = coef_r.green_from_cb;
        if (cfg_wr) coef_nxt.green_from_cb = cfg_pwdata[y2b_pkg::COEF_W-1:0];
      end
      y2b_pkg::REG_GREEN_FROM_CR: begin
        rd_coef = coef_r.green_from_cr;
        if (cfg_wr) coef_nxt.green_from_cr = cfg_pwdata[y2b_pkg::COEF_W-1:0];
      end
      y2b_pkg::REG_BLUE_FROM_CB: begin
        rd_coef = coef_r.blue_from_cb;
        if (cfg_wr) coef_nxt.blue_from_cb = cfg_pwdata[y2b_pkg::COEF_W-1:0];
      end
      default: begin
        rd_coef = '0;
      end
    endcase
  end

  assign cfg_prdata = y2b_pkg::DATA_W'(rd_coef);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.luma_gain     <= y2b_pkg::LUMA_GAIN_RST;
      coef_r.red_from_cr   <= y2b_pkg::RED_FROM_CR_RST;
      coef_r.green_from_cb <= y2b_pkg::GREEN_FROM_CB_RST;
      coef_r.green_from_cr <= y2b_pkg::GREEN_FROM_CR_RST;
      coef_r.blue_from_cb  <= y2b_pkg::BLUE_FROM_CB_RST;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  y2b_prep u_prep (
    .clk    (clk),
    .item_i (in_data),
    .comp_o (comp)
  );

  y2b_chroma u_chroma (
    .clk     (clk),
    .coef_i  (coef_r),
    .comp_i  (comp),
    .terms_o (terms)
  );

  y2b_lane #(
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_lane_first (
    .clk         (clk),
    .luma_gain_i (coef_r.luma_gain),
    .luma_i      (comp.luma_first),
    .terms_i     (terms),
    .pixel_o     (pixel_first)
  );

  y2b_lane #(
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_lane_second (
    .clk         (clk),
    .luma_gain_i (coef_r.luma_gain),
    .luma_i      (comp.luma_second),
    .terms_i     (terms),
    .pixel_o     (pixel_second)
  );

  always_comb begin
    out_nxt.blue_first   = pixel_first.blue;
    out_nxt.green_first  = pixel_first.green;
    out_nxt.red_first    = pixel_first.red;
    out_nxt.blue_second  = pixel_second.blue;
    out_nxt.green_second = pixel_second.green;
    out_nxt.red_second   = pixel_second.red;
    out_nxt.last_out     = last_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_a_r     <= accept;
      vld_b_r     <= vld_a_r;
      out_valid_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    last_a_r <= in_data.last_in;
    last_b_r <= last_a_r;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result strobe without an accepted item");

  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted item produced no result");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_out == $past(in_data.last_in, 3)))
    else $error("frame end flag out of step with its item");

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_psel && cfg_penable && cfg_pwrite) |-> $stable(coef_r))
    else $error("weights changed without a register write");

endmodule
